// ===== rtl/fir_rb_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_rb_pkg
// shared constants, state type and control structs of the ring buffer fir
// ----------------------------------------------------------------------------
`default_nettype none

package fir_rb_pkg;

  localparam int unsigned MaxTapsDef     = 256;
  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned CoefWidthDef   = 18;

  // q2.15 coefficients: drop 15 fraction bits from the sum
  localparam int unsigned ProductShift   = 15;
  localparam int unsigned TapCountReset  = 128;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_COEF   = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_WAIT1,
    S_WAIT2,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic push_sample;
    logic write_coef;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/fir_rb_ctrl.sv =====
// ----------------------------------------------------------------------------
// fir_rb_ctrl
// controller: input handshake and sequencing of the multiply-accumulate pass
// ----------------------------------------------------------------------------
`default_nettype none

module fir_rb_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_func_i,
  output logic                        in_ready_o,
  output fir_rb_pkg::dp_cmd_t         cmd_o,
  input  wire fir_rb_pkg::dp_status_t status_i
);
  import fir_rb_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == FUNC_COEF) begin
            cmd_o.write_coef = 1'b1;
          end else begin
            cmd_o.push_sample = 1'b1;
            state_d           = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = S_WAIT1;
        end
      end
      S_WAIT1: begin
        state_d = S_WAIT2;
      end
      S_WAIT2: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fir_rb_datapath.sv =====
// ----------------------------------------------------------------------------
// fir_rb_datapath
// delay line and coefficient memories, shared mac, saturation, output register
// ----------------------------------------------------------------------------
`default_nettype none

module fir_rb_datapath #(
  parameter int unsigned MAX_TAPS     = fir_rb_pkg::MaxTapsDef,
  parameter int unsigned SAMPLE_WIDTH = fir_rb_pkg::SampleWidthDef,
  parameter int unsigned COEF_WIDTH   = fir_rb_pkg::CoefWidthDef,
  localparam int unsigned IdxW        = $clog2(MAX_TAPS),
  localparam int unsigned TapW        = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fir_rb_pkg::dp_cmd_t            cmd_i,
  output fir_rb_pkg::dp_status_t              status_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [TapW-1:0]                cfg_wdata_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic [IdxW-1:0]                coef_index_i,
  input  wire logic signed [COEF_WIDTH-1:0]   coef_value_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]      filtered_o,
  output logic                                clipped_o
);
  import fir_rb_pkg::*;

  localparam int unsigned ProdW  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned AccRaw = ProdW + IdxW;
  localparam int unsigned AccW   = (AccRaw > SAMPLE_WIDTH + ProductShift) ?
                                   AccRaw : SAMPLE_WIDTH + ProductShift + 1;
  localparam int unsigned ShW    = AccW - ProductShift;
  localparam int unsigned TapRst = (TapCountReset > MAX_TAPS) ? MAX_TAPS : TapCountReset;

  localparam logic signed [ShW-1:0] SatMax =
    {{(ShW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ShW-1:0] SatMin =
    {{(ShW - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] dl_mem [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]            cf_vld_q;

  logic [TapW-1:0]                tap_q;
  logic [TapW-1:0]                fill_q;
  logic [IdxW-1:0]                wp_q;
  logic [TapW-1:0]                n_q;
  logic [IdxW-1:0]                rd_ptr_q;

  logic signed [SAMPLE_WIDTH-1:0] dl_rd_q;
  logic signed [COEF_WIDTH-1:0]   cf_rd_q;
  logic                           dl_ok_q, cf_ok_q, rd_v_q;
  logic signed [ProdW-1:0]        prod_q;
  logic                           prod_v_q;
  logic signed [AccW-1:0]         acc_q;

  logic                           out_valid_q, clipped_q;
  logic signed [SAMPLE_WIDTH-1:0] filtered_q;

  logic [TapW-1:0]                tap_clamped;
  logic signed [SAMPLE_WIDTH-1:0] dl_op;
  logic signed [COEF_WIDTH-1:0]   cf_op;
  logic signed [ShW-1:0]          shifted;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;
  logic                           sat_clip;

  // tap count register with clamp to 1..MAX_TAPS
  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      tap_clamped = TapW'(1);
    end else if (cfg_wdata_i > TapW'(MAX_TAPS)) begin
      tap_clamped = TapW'(MAX_TAPS);
    end else begin
      tap_clamped = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= TapW'(TapRst);
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      tap_q  <= tap_clamped;
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.push_sample) begin
      wp_q <= ((TapW'(wp_q) + TapW'(1)) == tap_q) ? '0 : wp_q + IdxW'(1);
      if (fill_q != TapW'(MAX_TAPS)) begin
        fill_q <= fill_q + TapW'(1);
      end
    end
  end

  // coefficient valid bits, cleared only by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_vld_q <= '0;
    end else if (cmd_i.write_coef && (TapW'(coef_index_i) < TapW'(MAX_TAPS))) begin
      cf_vld_q[coef_index_i] <= 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_sample) begin
      dl_mem[wp_q] <= sample_i;
    end
    if (cmd_i.write_coef && (TapW'(coef_index_i) < TapW'(MAX_TAPS))) begin
      cf_mem[coef_index_i] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_rd_q <= dl_mem[rd_ptr_q];
    cf_rd_q <= cf_mem[n_q[IdxW-1:0]];
    dl_ok_q <= TapW'(rd_ptr_q) < fill_q;
    cf_ok_q <= cf_vld_q[n_q[IdxW-1:0]];
  end

  // read sequencing: coefficient n meets the sample n steps back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      rd_ptr_q <= '0;
    end else if (cmd_i.push_sample) begin
      n_q      <= '0;
      rd_ptr_q <= wp_q;
    end else if (cmd_i.issue) begin
      n_q      <= n_q + TapW'(1);
      rd_ptr_q <= (rd_ptr_q == '0) ? IdxW'(tap_q - TapW'(1)) : rd_ptr_q - IdxW'(1);
    end
  end

  assign status_o.last_issue = (n_q + TapW'(1)) == tap_q;

  // multiply-accumulate pipeline
  assign dl_op = dl_ok_q ? dl_rd_q : '0;
  assign cf_op = cf_ok_q ? cf_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(dl_op) * ProdW'(cf_op);
    if (cmd_i.push_sample) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  // shift and saturate
  assign shifted = acc_q[AccW-1:ProductShift];

  always_comb begin
    priority if (shifted > SatMax) begin
      sat_val  = SatMax[SAMPLE_WIDTH-1:0];
      sat_clip = 1'b1;
    end else if (shifted < SatMin) begin
      sat_val  = SatMin[SAMPLE_WIDTH-1:0];
      sat_clip = 1'b1;
    end else begin
      sat_val  = shifted[SAMPLE_WIDTH-1:0];
      sat_clip = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      filtered_q <= sat_val;
      clipped_q  <= sat_clip;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign filtered_o        = filtered_q;
  assign clipped_o         = clipped_q;

endmodule

`default_nettype wire

// ===== rtl/fir_filter_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// fir_filter_ring_buffer
// direct form fir filter over a circular delay line with one shared mac
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_axis    in         tvalid/tready              tdata: sample, index, coef
//                                                  tuser: func
//  m_axis    out        tvalid/tready              tdata: filtered
//                                                  tuser: clipped
//  cfg       in         cfg_we_i                   cfg_wdata_i: tap count
//
//  a sample transfer occupies the block through its whole filter pass, with the
//  single multiply-accumulate unit reading one tap per cycle from each memory
//  a coefficient transfer is written and leaves the input ready for the next item
//  no clearing pass after reset: valid bits and a fill count stand in
//  a finished result waits in the output register while the next item enters
//  the result of the following sample waits for that register to drain
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_ring_buffer #(
  parameter int unsigned MAX_TAPS     = fir_rb_pkg::MaxTapsDef,
  parameter int unsigned SAMPLE_WIDTH = fir_rb_pkg::SampleWidthDef,
  parameter int unsigned COEF_WIDTH   = fir_rb_pkg::CoefWidthDef,
  localparam int unsigned IdxW        = $clog2(MAX_TAPS),
  localparam int unsigned TapW        = $clog2(MAX_TAPS + 1),
  localparam int unsigned InW         = ((SAMPLE_WIDTH + IdxW + COEF_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutW        = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TapW-1:0]  cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [InW-1:0]   s_axis_tdata,   // sample_in, coef_index, coef_value
  input  wire logic             s_axis_tuser,   // func
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OutW-1:0]       m_axis_tdata,   // filtered
  output logic                  m_axis_tuser    // clipped
);
  import fir_rb_pkg::*;

  dp_cmd_t                        cmd;
  dp_status_t                     status;
  logic signed [SAMPLE_WIDTH-1:0] filtered;

  fir_rb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  fir_rb_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .coef_index_i (s_axis_tdata[SAMPLE_WIDTH+IdxW-1:SAMPLE_WIDTH]),
    .coef_value_i (s_axis_tdata[SAMPLE_WIDTH+IdxW+COEF_WIDTH-1:SAMPLE_WIDTH+IdxW]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .filtered_o   (filtered),
    .clipped_o    (m_axis_tuser)
  );

  assign m_axis_tdata = OutW'($unsigned(filtered));

endmodule

`default_nettype wire

// ===== rtl/fir_rb_checker.sv =====
// ----------------------------------------------------------------------------
// fir_rb_checker
// port level checks of the ring buffer fir, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fir_rb_checker #(
  parameter int unsigned SAMPLE_WIDTH = fir_rb_pkg::SampleWidthDef,
  parameter int unsigned OutW         = 16
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            s_axis_tvalid,
  input wire logic            s_axis_tready,
  input wire logic            s_axis_tuser,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [OutW-1:0] m_axis_tdata,
  input wire logic            m_axis_tuser
);
  import fir_rb_pkg::*;

  localparam logic [SAMPLE_WIDTH-1:0] PosFull = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] NegFull = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output transfer changed");

  // a clipped result sits at one of the rails
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[SAMPLE_WIDTH-1:0] == PosFull) ||
      (m_axis_tdata[SAMPLE_WIDTH-1:0] == NegFull))
    else $error("clip flag without saturated value");

  // a sample transfer starts a filter pass
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_SAMPLE) |=> !s_axis_tready)
    else $error("input ready right after a sample transfer");

  // a coefficient transfer keeps the input open
  a_coef_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_COEF) |=> s_axis_tready)
    else $error("input stalled after a coefficient transfer");

endmodule

bind fir_filter_ring_buffer fir_rb_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .OutW         (OutW)
) u_fir_rb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/tb_fir_filter_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_fir_filter_ring_buffer
// self-checking bench for the ring buffer fir filter: a queue-fed driver sends
// sample and coefficient transfers with random gaps, a predictor mirrors the
// delay line, taps and saturation, and a monitor checks every output transfer
// against the oldest prediction over a series of tap count settings
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fir_filter_ring_buffer;
  import fir_rb_pkg::*;

  localparam int unsigned NTaps        = MaxTapsDef;
  localparam int          SatHi        = 32767;
  localparam int          SatLo        = -32768;
  localparam int          TapsRndSmall = 1000;
  localparam int          TapsRndLarge = 1001;
  localparam longint      CycleLimit   = 4_000_000;

  typedef struct {
    func_e             func;
    logic signed [15:0] sample;
    logic [7:0]         idx;
    logic signed [17:0] coef;
  } in_item_t;

  typedef struct {
    logic signed [15:0] filtered;
    logic               clipped;
  } fir_out_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  fir_filter_ring_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // filter state mirror
  logic signed [15:0] delay_mem [NTaps];
  logic signed [17:0] coef_mem  [NTaps];
  int                 wr_pos;
  int                 taps_model;

  in_item_t in_item_q [$];
  fir_out_t filtered_q [$];

  in_item_t drv_item;
  int       send_gap;
  int       recv_stall;
  bit       send_idle_en;
  bit       recv_idle_en;
  int       mismatch_cnt;
  longint   cycle_cnt;

  function automatic fir_out_t fir_predict(logic signed [15:0] s);
    longint   acc;
    longint   sh;
    int       k;
    fir_out_t r;
    delay_mem[wr_pos] = s;
    wr_pos = (wr_pos + 1) % taps_model;
    acc = 0;
    for (k = 0; k < taps_model; k++) begin
      acc += longint'(coef_mem[k]) *
             longint'(delay_mem[(wr_pos + taps_model - k - 1) % taps_model]);
    end
    sh = acc >>> ProductShift;
    r.clipped = 1'b1;
    if (sh > SatHi) begin
      r.filtered = 16'sh7fff;
    end else if (sh < SatLo) begin
      r.filtered = 16'sh8000;
    end else begin
      r.filtered = sh[15:0];
      r.clipped  = 1'b0;
    end
    return r;
  endfunction

  function automatic int clamp_taps(int v);
    if (v < 1) return 1;
    if (v > NTaps) return NTaps;
    return v;
  endfunction

  function automatic int next_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  function automatic logic [17:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 18'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 18'sh1ffff;
          1: return 18'sh20000;
          2: return 18'sh08000;
          default: return '0;
        endcase
      end
      2: return 18'($urandom_range(0, 8191) - 4096);
      default: return 18'($urandom_range(0, 65535) - 32768);
    endcase
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return 16'($urandom_range(0, 511) - 256);
    endcase
  endfunction

  task automatic push_coef(int idx, logic [17:0] val);
    in_item_t it;
    it.func   = FUNC_COEF;
    it.sample = 16'($urandom);
    it.idx    = 8'(idx);
    it.coef   = val;
    in_item_q.push_back(it);
  endtask

  task automatic push_sample(logic [15:0] s);
    in_item_t it;
    it.func   = FUNC_SAMPLE;
    it.sample = s;
    it.idx    = 8'($urandom);
    it.coef   = 18'($urandom);
    in_item_q.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (in_item_q.size() != 0 || s_axis_tvalid || filtered_q.size() != 0);
    repeat (taps_model + 10) @(posedge clk_i);
  endtask

  task automatic write_taps(int val);
    int k;
    @(posedge clk_i);
    cfg_wdata_i <= 9'(val);
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    taps_model = clamp_taps(val);
    wr_pos     = 0;
    for (k = 0; k < NTaps; k++) delay_mem[k] = '0;
  endtask

  task automatic report(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (in_item_q.size() != 0) begin
        drv_item       = in_item_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, drv_item.coef, drv_item.idx, drv_item.sample};
        s_axis_tuser  <= drv_item.func;
        send_gap      <= next_gap(send_idle_en);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= 0;
    end else if (recv_stall != 0) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= recv_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      recv_stall    <= next_gap(recv_idle_en);
    end
  end

  // input transfer: update the mirror and predict
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == FUNC_COEF) begin
        coef_mem[s_axis_tdata[23:16]] = s_axis_tdata[41:24];
      end else begin
        filtered_q.push_back(fir_predict(s_axis_tdata[15:0]));
      end
    end
  end

  // output transfer: compare with the oldest prediction
  always @(posedge clk_i) begin : out_check
    fir_out_t exp_out;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        report($sformatf("unexpected output: filtered=%0d clipped=%0b",
                         $signed(m_axis_tdata), m_axis_tuser));
      end else begin
        exp_out = filtered_q.pop_front();
        if (m_axis_tdata !== exp_out.filtered || m_axis_tuser !== exp_out.clipped) begin
          report($sformatf("mismatch: expected filtered=%0d clipped=%0b, got %0d %0b",
                           exp_out.filtered, exp_out.clipped,
                           $signed(m_axis_tdata), m_axis_tuser));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_fir_filter_ring_buffer: FAIL");
      $finish;
    end
  end

  initial begin
    int phase_taps [16];
    int p;
    int k;
    int v;
    int eff;
    int n_samp;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    taps_model   = TapCountReset;
    wr_pos       = 0;
    for (k = 0; k < NTaps; k++) begin
      delay_mem[k] = '0;
      coef_mem[k]  = '0;
    end
    phase_taps = '{1, 0, 2, 3, 511, 5, 16, 256, TapsRndSmall, TapsRndSmall,
                   TapsRndSmall, TapsRndSmall, TapsRndSmall, TapsRndLarge, 1, 128};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default tap count, coefficient extremes, clipping both ways
    push_sample(16'sh1234);
    push_coef(0, 18'sh1ffff);
    push_coef(1, 18'sh20000);
    push_coef(127, 18'sh08000);
    push_coef(200, 18'sh0004d);
    push_coef(255, 18'sh3ffff);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'shffff);
    push_sample(16'sh0001);
    push_coef(0, 18'sh00001);
    push_coef(1, 18'sh00000);
    push_sample(16'shffff);
    push_sample(16'sh0001);
    push_coef(0, 18'sh08000);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_coef(0, 18'sh20000);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_coef(127, 18'sh00000);
    wait_drained();

    for (p = 0; p < 16; p++) begin
      v = phase_taps[p];
      if (v == TapsRndSmall) v = $urandom_range(4, 48);
      if (v == TapsRndLarge) v = $urandom_range(65, 255);
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      write_taps(v);
      eff = clamp_taps(v);
      if (eff <= 32) begin
        for (k = 0; k < eff; k++) push_coef(k, rand_coef());
      end else begin
        for (k = 0; k < 24; k++) push_coef($urandom_range(0, eff - 1), rand_coef());
      end
      n_samp = (eff > 64) ? 30 : 70;
      for (k = 0; k < n_samp; k++) begin
        if ($urandom_range(0, 9) == 0) push_coef($urandom_range(0, 255), rand_coef());
        push_sample(rand_sample());
      end
      wait_drained();
    end

    if (mismatch_cnt == 0 && filtered_q.size() == 0) begin
      $display("tb_fir_filter_ring_buffer: PASS");
    end else begin
      $display("tb_fir_filter_ring_buffer: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
